// ===== rtl/lam_pkg.sv =====
// Shared widths and configuration register indexes for the approximate word matcher.
package lam_pkg;

   localparam int CHAR_W     = 8;
   localparam int WORD_W     = 64;
   localparam int LEN_W      = 6;
   localparam int LIMIT_W    = 2;
   localparam int DIST_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int PAT_WORDS  = 4;
   localparam int LAYER_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAT_0_7   = 3'd0,
      CSR_PAT_8_15  = 3'd1,
      CSR_PAT_16_23 = 3'd2,
      CSR_PAT_24_31 = 3'd3,
      CSR_LENGTH    = 3'd4,
      CSR_LIMIT     = 3'd5
   } csr_idx_type;

endpackage

// ===== rtl/lam_if.sv =====
// Channel interfaces of the approximate word matcher: text bytes, results and register writes.
interface lam_req_if;
   logic                       valid;
   logic                       ready;
   logic [lam_pkg::CHAR_W-1:0] text_char;
   logic                       word_end;

   modport source (output valid, output text_char, output word_end, input ready);
   modport sink   (input valid, input text_char, input word_end, output ready);
endinterface

interface lam_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       matched;
   logic [lam_pkg::DIST_W-1:0] distance;

   modport source (output valid, output matched, output distance, input ready);
   modport sink   (input valid, input matched, input distance, output ready);
endinterface

interface lam_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lam_pkg::CSR_IDX_W-1:0] index;
   logic [lam_pkg::WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/levenshtein_automaton_match.sv =====
// Top level of the approximate word matcher: a bit-parallel Levenshtein automaton.
//
// Text words arrive one byte per beat on req_bus (text_char, word_end). For
// each error layer a vector of active pattern positions is kept; every byte
// advances all layers by match, insertion and substitution, then closes the
// deletion moves. The beat that carries word_end produces one beat on rsp_bus
// (matched, distance); other beats produce nothing. The next byte re-seeds the
// vectors from the start state under the current registers.
// Pattern bytes, pattern length and error limit are written on csr_bus, which
// is always ready; write them only while no byte is in flight.
// Throughput: one byte per cycle while no word-end byte waits on a held result. A
// result passes through the input register, then the result register. The
// only recurrence is the vector update, one combinational pass of compare,
// shift and a closure chain across the error layers.
// A held result on a stalled rsp_bus stops only a waiting word-end byte; other
// bytes keep flowing. Reset clears the configuration, valid flags and automaton state, and arms the seed.
module levenshtein_automaton_match #(
   parameter int MAX_PATTERN = 32,
   parameter int MAX_ERRORS  = 3
) (
   input  logic clock,
   input  logic reset,
   lam_req_if.sink   req_bus,
   lam_rsp_if.source rsp_bus,
   lam_csr_if.sink   csr_bus
);

   localparam int VW = MAX_PATTERN + 1;
   localparam int PAT_WORDS_C = lam_pkg::PAT_WORDS;

   typedef logic [MAX_ERRORS:0][VW-1:0] layers_type;

   // Configuration registers
   logic [PAT_WORDS_C-1:0][lam_pkg::WORD_W-1:0] pat_ff;
   logic [lam_pkg::LEN_W-1:0]   len_cfg_ff;
   logic [lam_pkg::LIMIT_W-1:0] limit_cfg_ff;

   // Input stage
   logic                       in_valid_ff;
   logic [lam_pkg::CHAR_W-1:0] in_char_ff;
   logic                       in_end_ff;

   // Automaton state
   layers_type act_ff;
   layers_type act_in;
   logic       word_start_ff;

   // Result stage
   logic                       rsp_valid_ff;
   logic                       rsp_matched_ff;
   logic [lam_pkg::DIST_W-1:0] rsp_dist_ff;
   logic                       rsp_matched_in;
   logic [lam_pkg::DIST_W-1:0] rsp_dist_in;

   logic                                s1_fire;
   logic [lam_pkg::LEN_W-1:0]           len_eff;
   logic [lam_pkg::LAYER_IDX_W-1:0]     k_eff;
   logic [VW-1:0]                       low_mask;
   logic [VW-1:0]                       all_mask;
   logic [VW-1:0]                       hit;
   logic [MAX_ERRORS:0]                 layer_en;
   layers_type                          seed_vec;
   layers_type                          cur;
   layers_type                          raw;
   logic [lam_pkg::LAYER_IDX_W-1:0]     dist_sel;
   logic                                any_fin;

   // Deletion closure: layer e position i feeds layer e+1 position i+1
   function automatic layers_type close_layers(input layers_type v,
                                               input logic [VW-1:0] low,
                                               input logic [VW-1:0] all,
                                               input logic [MAX_ERRORS:0] en);
      layers_type r;
      r = '0;
      for (int e = 0; e <= MAX_ERRORS; e++) begin
         if (en[e]) begin
            if (e > 0) begin
               r[e] = (v[e] | ((r[e-1] & low) << 1)) & all;
            end else begin
               r[e] = v[e] & all;
            end
         end
      end
      return r;
   endfunction

   // Saturate length and limit, build position masks
   always_comb begin
      if (len_cfg_ff > lam_pkg::LEN_W'(MAX_PATTERN)) begin
         len_eff = lam_pkg::LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = len_cfg_ff;
      end
      if (lam_pkg::LAYER_IDX_W'(limit_cfg_ff) > lam_pkg::LAYER_IDX_W'(MAX_ERRORS)) begin
         k_eff = lam_pkg::LAYER_IDX_W'(MAX_ERRORS);
      end else begin
         k_eff = lam_pkg::LAYER_IDX_W'(limit_cfg_ff);
      end
      for (int i = 0; i < VW; i++) begin
         low_mask[i] = lam_pkg::LEN_W'(i) < len_eff;
         all_mask[i] = lam_pkg::LEN_W'(i) <= len_eff;
      end
      for (int e = 0; e <= MAX_ERRORS; e++) begin
         layer_en[e] = lam_pkg::LAYER_IDX_W'(e) <= k_eff;
      end
   end

   // Compare the text byte against every pattern position in use
   always_comb begin
      hit = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         hit[i] = low_mask[i] &&
                  (pat_ff[i / 8][(i % 8) * 8 +: lam_pkg::CHAR_W] == in_char_ff);
      end
   end

   // Advance every layer and close
   always_comb begin
      seed_vec       = '0;
      seed_vec[0][0] = 1'b1;
      if (word_start_ff) begin
         cur = close_layers(seed_vec, low_mask, all_mask, layer_en);
      end else begin
         cur = act_ff;
      end
      raw = '0;
      for (int e = 0; e <= MAX_ERRORS; e++) begin
         raw[e] = (cur[e] & hit) << 1;
         if (e > 0) begin
            raw[e] = raw[e] | cur[e-1] | ((cur[e-1] & low_mask) << 1);
         end
      end
      act_in = close_layers(raw, low_mask, all_mask, layer_en);
   end

   // Lowest layer that reached the final position
   always_comb begin
      dist_sel = '0;
      any_fin  = 1'b0;
      for (int e = MAX_ERRORS; e >= 0; e--) begin
         if (|(act_in[e] & all_mask & ~low_mask)) begin
            dist_sel = lam_pkg::LAYER_IDX_W'(e);
            any_fin  = 1'b1;
         end
      end
      rsp_matched_in = any_fin;
      rsp_dist_in    = dist_sel[lam_pkg::DIST_W-1:0];
   end

   // Handshakes: a word-end byte waits only for room in the result register
   assign s1_fire       = in_valid_ff && (!in_end_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || s1_fire;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.matched  = rsp_matched_ff;
   assign rsp_bus.distance = rsp_dist_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         len_cfg_ff   <= '0;
         limit_cfg_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (lam_pkg::csr_idx_type'(csr_bus.index))
            lam_pkg::CSR_PAT_0_7:   pat_ff[0]    <= csr_bus.data;
            lam_pkg::CSR_PAT_8_15:  pat_ff[1]    <= csr_bus.data;
            lam_pkg::CSR_PAT_16_23: pat_ff[2]    <= csr_bus.data;
            lam_pkg::CSR_PAT_24_31: pat_ff[3]    <= csr_bus.data;
            lam_pkg::CSR_LENGTH:    len_cfg_ff   <= csr_bus.data[lam_pkg::LEN_W-1:0];
            lam_pkg::CSR_LIMIT:     limit_cfg_ff <= csr_bus.data[lam_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready && req_bus.valid) begin
         in_char_ff <= req_bus.text_char;
         in_end_ff  <= req_bus.word_end;
      end
   end

   // Automaton state: advance on each byte, re-arm the seed after a word end
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff        <= '0;
         word_start_ff <= 1'b1;
      end else if (s1_fire) begin
         act_ff        <= act_in;
         word_start_ff <= in_end_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && in_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_fire && in_end_ff) begin
         rsp_matched_ff <= rsp_matched_in;
         rsp_dist_ff    <= rsp_matched_in ? rsp_dist_in : '0;
      end
   end

   // A new result only follows a word-end byte leaving the input register
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire && in_end_ff))
      else $error("result appeared without a word-end byte");

   // An unmatched word reports zero distance
   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_matched_ff |-> rsp_dist_ff == '0)
      else $error("distance set on an unmatched word");

   // A word end re-arms the seed for the following byte
   a_reseed: assert property (@(posedge clock) disable iff (reset)
      s1_fire && in_end_ff |=> word_start_ff)
      else $error("seed not re-armed after word end");

   // Input stalls only behind a held result and a waiting word-end byte
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> in_valid_ff && in_end_ff && rsp_valid_ff && !rsp_bus.ready)
      else $error("input stalled without cause");

endmodule
